/* rtl/core/ffat_pkg.sv */
// Shared types, constants and codes of the flow fan aggregation table.
// Used by every module and interface of the block except ffat_ram; depends on nothing.
`default_nettype none

package ffat_pkg;

    localparam int unsigned OUT_ENTRIES_DEF = 256;
    localparam int unsigned IN_ENTRIES_DEF  = 256;
    localparam int unsigned TOTAL_WIDTH_DEF = 48;
    localparam int unsigned QUEUE_DEPTH     = 2;

    localparam int unsigned CFG_W     = 48;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_PROTOCOL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_MINUTES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_BASE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FANOUT_BYTES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FANIN_FLOWS  = 3'd4;

    localparam logic [2:0] ST_COUNTED     = 3'd0;
    localparam logic [2:0] ST_WRONG_PROTO = 3'd1;
    localparam logic [2:0] ST_OUT_FULL    = 3'd2;
    localparam logic [2:0] ST_IN_FULL     = 3'd3;
    localparam logic [2:0] ST_BOTH_FULL   = 3'd4;

    localparam int unsigned MS_PER_MINUTE = 60000;
    localparam int unsigned INTERVAL_W    = 27;
    localparam int unsigned DIV_STEPS     = 48;
    localparam int unsigned DIV_CNT_W     = 6;

    typedef struct packed {
        logic [7:0]  protocol_number;
        logic [47:0] flow_start_ms;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [31:0] byte_count;
        logic [31:0] packet_count;
        logic [31:0] reverse_bytes;
        logic [31:0] reverse_packets;
    } rec_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] bucket;
        logic [47:0] out_bytes_total;
        logic [47:0] out_packets_total;
        logic [47:0] out_rev_bytes_total;
        logic [47:0] out_rev_packets_total;
        logic [31:0] out_flow_total;
        logic [31:0] in_flow_total;
        logic        fanout_met;
        logic        fanin_met;
    } res_t;

    typedef struct packed {
        logic        wrong;
        logic [31:0] bucket;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] bytes;
        logic [31:0] pkts;
        logic [31:0] rbytes;
        logic [31:0] rpkts;
    } work_t;

    typedef struct packed {
        logic done;
        logic hit;
        logic full;
    } lk_stat_t;

    typedef enum logic [2:0] {F_IDLE, F_PREP, F_DIV, F_FIX, F_PUSH} front_state_t;
    typedef enum logic [1:0] {B_IDLE, B_LOOK, B_CALC, B_EMIT} back_state_t;
    typedef enum logic [1:0] {L_IDLE, L_SCAN, L_DONE} look_state_t;

endpackage

`default_nettype wire

/* rtl/core/ffat_if.sv */
// Stream interfaces for flow records and aggregation results.
// Depends on ffat_pkg for the payload types.
`default_nettype none

interface ffat_rec_if import ffat_pkg::*; ();
    logic valid;
    logic ready;
    rec_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface ffat_res_if import ffat_pkg::*; ();
    logic valid;
    logic ready;
    res_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/ffat_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module ffat_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/ffat_queue.sv */
// Short queue of classified words between the front and back ends.
// Depends on ffat_pkg for the word type.
`default_nettype none

module ffat_queue import ffat_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire work_t push_data,
    output logic       full,
    input  wire logic  pop,
    output logic       valid,
    output work_t      pop_data
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    work_t           mem_reg [DEPTH];
    logic [PW-1:0]   wptr_reg, wptr_next;
    logic [PW-1:0]   rptr_reg, rptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ffat_front.sv */
// Front end: accepts flow records, checks protocol, divides for the bucket.
// Depends on ffat_pkg; feeds ffat_queue.
`default_nettype none

module ffat_front import ffat_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        rec_valid,
    output logic             rec_ready,
    input  wire rec_t        rec_data,
    input  wire logic [7:0]  match_protocol,
    input  wire logic [10:0] bucket_minutes,
    input  wire logic [31:0] bucket_base,
    output logic             q_push,
    output work_t            q_data,
    input  wire logic        q_full
);

    front_state_t              state_reg, state_next;
    logic                      started_reg, started_next;
    logic [47:0]               start_time_reg, start_time_next;
    logic [48:0]               diff_reg, diff_next;
    logic                      neg_reg, neg_next;
    logic [INTERVAL_W-1:0]     interval_reg, interval_next;
    logic [INTERVAL_W:0]       rem_reg, rem_next;
    logic [47:0]               quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    work_t                     word_reg, word_next;
    logic [INTERVAL_W:0]       trial;
    logic [10:0]               minutes_eff;
    logic [31:0]               quo_low;
    logic [47:0]               base_time;

    assign q_data = word_reg;

    always_comb
    begin
        state_next      = state_reg;
        started_next    = started_reg;
        start_time_next = start_time_reg;
        diff_next       = diff_reg;
        neg_next        = neg_reg;
        interval_next   = interval_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        word_next       = word_reg;
        rec_ready       = 1'b0;
        q_push          = 1'b0;
        trial           = {rem_reg[INTERVAL_W-1:0], quo_reg[47]};
        minutes_eff     = (bucket_minutes == '0) ? 11'd1 : bucket_minutes;
        quo_low         = neg_reg ? (32'd0 - quo_reg[31:0]) : quo_reg[31:0];
        base_time       = started_reg ? start_time_reg : rec_data.flow_start_ms;
        case (state_reg)
            F_IDLE:
            begin
                rec_ready = 1'b1;
                if (rec_valid)
                begin
                    word_next.src    = rec_data.source_address;
                    word_next.dst    = rec_data.dest_address;
                    word_next.bytes  = rec_data.byte_count;
                    word_next.pkts   = rec_data.packet_count;
                    word_next.rbytes = rec_data.reverse_bytes;
                    word_next.rpkts  = rec_data.reverse_packets;
                    word_next.bucket = '0;
                    if (rec_data.protocol_number != match_protocol)
                    begin
                        word_next.wrong = 1'b1;
                        state_next      = F_PUSH;
                    end
                    else
                    begin
                        word_next.wrong = 1'b0;
                        if (!started_reg)
                        begin
                            started_next    = 1'b1;
                            start_time_next = rec_data.flow_start_ms;
                        end
                        diff_next  = {1'b0, rec_data.flow_start_ms} - {1'b0, base_time};
                        state_next = F_PREP;
                    end
                end
            end
            F_PREP:
            begin
                neg_next      = diff_reg[48];
                quo_next      = diff_reg[48] ? 48'(49'd0 - diff_reg) : diff_reg[47:0];
                interval_next = INTERVAL_W'(minutes_eff) * INTERVAL_W'(MS_PER_MINUTE);
                rem_next      = '0;
                cnt_next      = '0;
                state_next    = F_DIV;
            end
            F_DIV:
            begin
                if (trial >= {1'b0, interval_reg})
                begin
                    rem_next = trial - {1'b0, interval_reg};
                    quo_next = {quo_reg[46:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[46:0], 1'b0};
                end
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = F_FIX;
                end
            end
            F_FIX:
            begin
                word_next.bucket = bucket_base + quo_low;
                state_next       = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            started_reg    <= 1'b0;
            start_time_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            started_reg    <= started_next;
            start_time_reg <= start_time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg     <= diff_next;
        neg_reg      <= neg_next;
        interval_reg <= interval_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        word_reg     <= word_next;
    end

endmodule

`default_nettype wire

/* rtl/core/ffat_lookup.sv */
// One keyed table: linear key search over a RAM, then write back of the entry.
// Depends on ffat_pkg and ffat_ram.
`default_nettype none

module ffat_lookup import ffat_pkg::*; #(
    parameter int unsigned ENTRIES = OUT_ENTRIES_DEF,
    parameter int unsigned DATA_W  = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [63:0]       key,
    input  wire logic              commit,
    input  wire logic [DATA_W-1:0] wdata,
    output lk_stat_t               stat,
    output logic      [DATA_W-1:0] rdata
);

    localparam int unsigned IW = $clog2(ENTRIES);
    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam int unsigned EW = 64 + DATA_W;

    look_state_t       state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     issue_reg, issue_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [CW-1:0]     chk_idx_reg, chk_idx_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              hit_reg, hit_next;
    logic [63:0]       key_reg, key_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic              rd_en, wr_en, full, match, last;
    logic [EW-1:0]     ram_q;

    ffat_ram #(
        .WIDTH(EW),
        .DEPTH(ENTRIES)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(idx_reg[IW-1:0]),
        .wr_data({key_reg, wdata}),
        .rd_en  (rd_en),
        .rd_addr(issue_reg[IW-1:0]),
        .rd_data(ram_q)
    );

    assign full      = !hit_reg && (count_reg == CW'(ENTRIES));
    assign match     = chk_valid_reg && (ram_q[EW-1 -: 64] == key_reg);
    assign last      = chk_valid_reg && (chk_idx_reg == count_reg - CW'(1));
    assign rd_en     = (state_reg == L_SCAN) && (issue_reg < count_reg);
    assign wr_en     = (state_reg == L_DONE) && commit && !full;
    assign stat.done = (state_reg == L_DONE);
    assign stat.hit  = hit_reg;
    assign stat.full = full;
    assign rdata     = hit_reg ? data_reg : '0;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        key_next       = key_reg;
        data_next      = data_reg;
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    key_next   = key;
                    issue_next = '0;
                    hit_next   = 1'b0;
                    idx_next   = count_reg;
                    state_next = (count_reg == '0) ? L_DONE : L_SCAN;
                end
            end
            L_SCAN:
            begin
                chk_valid_next = rd_en;
                chk_idx_next   = issue_reg;
                if (rd_en)
                begin
                    issue_next = issue_reg + CW'(1);
                end
                if (match)
                begin
                    hit_next   = 1'b1;
                    idx_next   = chk_idx_reg;
                    data_next  = ram_q[DATA_W-1:0];
                    state_next = L_DONE;
                end
                else if (last)
                begin
                    hit_next   = 1'b0;
                    idx_next   = count_reg;
                    state_next = L_DONE;
                end
            end
            L_DONE:
            begin
                if (commit)
                begin
                    if (wr_en && !hit_reg)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    state_next = L_IDLE;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= L_IDLE;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg   <= issue_next;
        chk_idx_reg <= chk_idx_next;
        idx_reg     <= idx_next;
        hit_reg     <= hit_next;
        key_reg     <= key_next;
        data_reg    <= data_next;
    end

endmodule

`default_nettype wire

/* rtl/core/ffat_back.sv */
// Back end: looks up both tables, updates saturating totals, drives results.
// Depends on ffat_pkg and ffat_lookup.
`default_nettype none

module ffat_back import ffat_pkg::*; #(
    parameter int unsigned OUT_ENTRIES = OUT_ENTRIES_DEF,
    parameter int unsigned IN_ENTRIES  = IN_ENTRIES_DEF,
    parameter int unsigned TOTAL_WIDTH = TOTAL_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire work_t       q_data,
    output logic             q_pop,
    input  wire logic [47:0] min_fanout_bytes,
    input  wire logic [31:0] min_fanin_flows,
    output logic             res_valid,
    input  wire logic        res_ready,
    output res_t             res_data
);

    localparam int unsigned TW   = TOTAL_WIDTH;
    localparam int unsigned OD_W = 4 * TW + 32;

    back_state_t     state_reg, state_next;
    work_t           work_reg, work_next;
    logic [TW-1:0]   ob_reg, ob_next, op_reg, op_next;
    logic [TW-1:0]   orb_reg, orb_next, orp_reg, orp_next;
    logic [31:0]     of_reg, of_next, if_reg, if_next;
    logic            res_valid_reg, res_valid_next;
    res_t            res_data_reg, res_data_next;
    logic            lk_start, commit;
    lk_stat_t        out_stat, in_stat;
    logic [OD_W-1:0] out_rd;
    logic [31:0]     in_rd;

    function automatic logic [TW-1:0] sat_tot(input logic [TW-1:0] a, input logic [31:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + (TW + 1)'(b);
        return s[TW] ? '1 : s[TW-1:0];
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] a);
        return (a == '1) ? a : a + 32'd1;
    endfunction

    ffat_lookup #(
        .ENTRIES(OUT_ENTRIES),
        .DATA_W (OD_W)
    ) u_out_lk (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lk_start),
        .key   ({q_data.bucket, q_data.src}),
        .commit(commit),
        .wdata ({ob_reg, op_reg, orb_reg, orp_reg, of_reg}),
        .stat  (out_stat),
        .rdata (out_rd)
    );

    ffat_lookup #(
        .ENTRIES(IN_ENTRIES),
        .DATA_W (32)
    ) u_in_lk (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lk_start),
        .key   ({q_data.bucket, q_data.dst}),
        .commit(commit),
        .wdata (if_reg),
        .stat  (in_stat),
        .rdata (in_rd)
    );

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        ob_next        = ob_reg;
        op_next        = op_reg;
        orb_next       = orb_reg;
        orp_next       = orp_reg;
        of_next        = of_reg;
        if_next        = if_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_data_next  = res_data_reg;
        q_pop          = 1'b0;
        lk_start       = 1'b0;
        commit         = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    work_next  = q_data;
                    lk_start   = !q_data.wrong;
                    state_next = q_data.wrong ? B_EMIT : B_LOOK;
                end
            end
            B_LOOK:
            begin
                if (out_stat.done && in_stat.done)
                begin
                    state_next = B_CALC;
                end
            end
            B_CALC:
            begin
                ob_next    = sat_tot(out_rd[OD_W-1 -: TW], work_reg.bytes);
                op_next    = sat_tot(out_rd[OD_W-TW-1 -: TW], work_reg.pkts);
                orb_next   = sat_tot(out_rd[OD_W-2*TW-1 -: TW], work_reg.rbytes);
                orp_next   = sat_tot(out_rd[OD_W-3*TW-1 -: TW], work_reg.rpkts);
                of_next    = sat_inc(out_rd[31:0]);
                if_next    = sat_inc(in_rd);
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    commit         = !work_reg.wrong;
                    res_valid_next = 1'b1;
                    res_data_next  = '0;
                    if (work_reg.wrong)
                    begin
                        res_data_next.status = ST_WRONG_PROTO;
                    end
                    else
                    begin
                        res_data_next.bucket = work_reg.bucket;
                        if (out_stat.full && in_stat.full)
                        begin
                            res_data_next.status = ST_BOTH_FULL;
                        end
                        else if (out_stat.full)
                        begin
                            res_data_next.status = ST_OUT_FULL;
                        end
                        else if (in_stat.full)
                        begin
                            res_data_next.status = ST_IN_FULL;
                        end
                        else
                        begin
                            res_data_next.status = ST_COUNTED;
                        end
                        if (!out_stat.full)
                        begin
                            res_data_next.out_bytes_total       = 48'(ob_reg);
                            res_data_next.out_packets_total     = 48'(op_reg);
                            res_data_next.out_rev_bytes_total   = 48'(orb_reg);
                            res_data_next.out_rev_packets_total = 48'(orp_reg);
                            res_data_next.out_flow_total        = of_reg;
                            res_data_next.fanout_met =
                                (64'(ob_reg) >= 64'(min_fanout_bytes));
                        end
                        if (!in_stat.full)
                        begin
                            res_data_next.in_flow_total = if_reg;
                            res_data_next.fanin_met     = (if_reg >= min_fanin_flows);
                        end
                    end
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        ob_reg       <= ob_next;
        op_reg       <= op_next;
        orb_reg      <= orb_next;
        orp_reg      <= orp_next;
        of_reg       <= of_next;
        if_reg       <= if_next;
        res_data_reg <= res_data_next;
    end

endmodule

`default_nettype wire

/* rtl/core/flow_fan_aggregation_table.sv */
// Flow fan aggregation table: per host fan-in and fan-out counts per time bucket.
// Flow records enter on rec (valid/ready); one result word leaves on res per
// record, in order. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while the block is idle, which the block itself
// does not enforce. Indexes beyond the register list are ignored. The front end
// takes one record at a time and finds the bucket number with a 48-step
// restoring divider; a record of another protocol skips the divider. The back
// end searches the source and destination tables in parallel, one entry per
// cycle from each key RAM, up to the fill count of each table (up to
// OUT_ENTRIES or IN_ENTRIES). A two-word queue lets the front divide the next
// record while the back searches. Results sit in an output register; while the
// receiver stalls, the back end holds its next result and the front fills the
// queue, then rec.ready drops. Reset empties both tables and the queue, clears
// the start time and loads the register defaults; no clearing pass is needed.
// Depends on ffat_pkg, ffat_if, ffat_front, ffat_queue, ffat_back.
`default_nettype none

module flow_fan_aggregation_table import ffat_pkg::*; #(
    parameter int unsigned OUT_ENTRIES = OUT_ENTRIES_DEF,
    parameter int unsigned IN_ENTRIES  = IN_ENTRIES_DEF,
    parameter int unsigned TOTAL_WIDTH = TOTAL_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    ffat_rec_if.sink                  rec,
    ffat_res_if.source                res,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic [7:0]  match_protocol_reg;
    logic [10:0] bucket_minutes_reg;
    logic [31:0] bucket_base_reg;
    logic [47:0] min_fanout_bytes_reg;
    logic [31:0] min_fanin_flows_reg;
    logic        q_push, q_full, q_pop, q_valid;
    work_t       q_in, q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_protocol_reg   <= 8'd6;
            bucket_minutes_reg   <= 11'd5;
            bucket_base_reg      <= 32'd500000;
            min_fanout_bytes_reg <= '0;
            min_fanin_flows_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MATCH_PROTOCOL:   match_protocol_reg   <= cfg_data[7:0];
                CFG_BUCKET_MINUTES:   bucket_minutes_reg   <= cfg_data[10:0];
                CFG_BUCKET_BASE:      bucket_base_reg      <= cfg_data[31:0];
                CFG_MIN_FANOUT_BYTES: min_fanout_bytes_reg <= cfg_data[47:0];
                CFG_MIN_FANIN_FLOWS:  min_fanin_flows_reg  <= cfg_data[31:0];
                default:              ;
            endcase
        end
    end

    ffat_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_valid     (rec.valid),
        .rec_ready     (rec.ready),
        .rec_data      (rec.data),
        .match_protocol(match_protocol_reg),
        .bucket_minutes(bucket_minutes_reg),
        .bucket_base   (bucket_base_reg),
        .q_push        (q_push),
        .q_data        (q_in),
        .q_full        (q_full)
    );

    ffat_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_in),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_data (q_out)
    );

    ffat_back #(
        .OUT_ENTRIES(OUT_ENTRIES),
        .IN_ENTRIES (IN_ENTRIES),
        .TOTAL_WIDTH(TOTAL_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_data          (q_out),
        .q_pop           (q_pop),
        .min_fanout_bytes(min_fanout_bytes_reg),
        .min_fanin_flows (min_fanin_flows_reg),
        .res_valid       (res.valid),
        .res_ready       (res.ready),
        .res_data        (res.data)
    );

endmodule

`default_nettype wire
